FILE: design/phmdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package phmdc_pkg;
    localparam int PATCH_ELEMS   = 64;
    localparam int TABLE_ENTRIES = 1024;
    localparam int POS_W   = $clog2(PATCH_ELEMS);
    localparam int CNT_W   = $clog2(PATCH_ELEMS + 1);
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int MADDR_W = IDX_W + POS_W;
    localparam logic [63:0] HASH_SEED = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] ELEM_SALT = 64'h517cc1b727220a95;
    localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MIX, ST_FOLD, ST_FMIX, ST_LOOK, ST_LOOK2,
        ST_CLEAR, ST_WALK_RD, ST_WALK_WAIT, ST_WALK_DO, ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } t_mix_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_mix_rsp;

    function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
        if (v > 36'sd8388607) begin
            return 24'sh7fffff;
        end else if (v < -36'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction
endpackage
`default_nettype wire

FILE: design/phmdc_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
module phmdc_mixer
    import phmdc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mix_req i_req,
    output t_mix_rsp      o_rsp
);
    // One 32x32 multiplier builds each 64-bit product from three partial products.
    logic [63:0] r_k, n_k;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_step, n_step;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;
    logic [63:0] mulc;
    logic [63:0] ks;

    assign mul_p = 64'(mul_x) * 64'(mul_y);
    assign ks    = r_k ^ (r_k >> 33);
    assign mulc  = (r_step < 4'd5) ? MIX_MUL_A : MIX_MUL_B;

    always_comb begin
        mul_x = ks[31:0];
        mul_y = mulc[31:0];
        case (r_step)
            4'd2, 4'd6: begin
                mul_x = ks[31:0];
                mul_y = mulc[63:32];
            end
            4'd3, 4'd7: begin
                mul_x = ks[63:32];
                mul_y = mulc[31:0];
            end
            default: begin
                mul_x = ks[31:0];
                mul_y = mulc[31:0];
            end
        endcase
    end

    always_comb begin
        n_k = r_k;
        n_acc = r_acc;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_k = i_req.operand;
            n_step = 4'd1;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_step = r_step + 4'd1;
            case (r_step)
                4'd1, 4'd5: n_acc = mul_p;
                4'd2, 4'd6: n_acc = r_acc + {mul_p[31:0], 32'd0};
                4'd3, 4'd7: n_acc = r_acc + {mul_p[31:0], 32'd0};
                4'd4: n_k = r_acc;
                4'd8: begin
                    n_k = r_acc;
                end
                4'd9: begin
                    n_k = ks;
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
                default: n_step = r_step;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        r_acc <= n_acc;
        r_step <= n_step;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_k;
endmodule
`default_nettype wire

FILE: design/patch_hash_momentum_draft_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// A non-closing element goes through one 64-bit mix in the shared 32x32 multiplier,
// one hash fold and the return to idle; no input is taken meanwhile.
// The closing element adds a final mix and a table lookup, then walks the patch.
// Output back-pressure holds the walk at each query beat while that beat waits.
// After reset a clearing pass over all TABLE_ENTRIES entries clears the tag, hit and fill stores.
module patch_hash_momentum_draft_cache
    import phmdc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // value_a, value_b
    input  wire logic        s_axis_tlast,  // last
    input  wire logic        s_axis_tuser,  // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // out_value
    output logic             m_axis_tlast,  // out_last
    output logic             m_axis_tuser,  // accepted
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);
    t_state r_state, n_state;
    logic [7:0]  r_thr;
    logic [63:0] r_hash, n_hash;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [POS_W-1:0] r_i, n_i;
    logic        r_mode, n_mode;
    logic        r_close, n_close;
    logic [63:0] r_h, n_h;
    logic        r_acc, n_acc;
    logic        r_hit, n_hit;
    logic [IDX_W-1:0] r_clr, n_clr;
    logic        r_ovalid, n_ovalid;
    logic [23:0] r_oval, n_oval;
    logic        r_olast, n_olast;
    logic        r_oacc, n_oacc;
    t_mix_req    mreq;
    t_mix_rsp    mrsp;

    logic signed [23:0] buf_a [PATCH_ELEMS];
    logic signed [23:0] buf_b [PATCH_ELEMS];
    logic [63:0] tag_mem [TABLE_ENTRIES];
    logic [7:0]  hit_mem [TABLE_ENTRIES];
    logic [CNT_W-1:0] fill_mem [TABLE_ENTRIES];
    logic signed [23:0] mom_mem [TABLE_ENTRIES * PATCH_ELEMS];
    logic [63:0] r_tag_rd;
    logic [7:0]  r_hit_rd;
    logic [CNT_W-1:0] r_fill_rd, r_fill;
    logic signed [23:0] r_mom_rd, r_a_rd, r_b_rd;
    logic        r_mom_ok;
    logic        w_tag;
    logic [7:0]  w_hitv;
    logic [CNT_W-1:0] w_fillv;
    logic        w_mom;
    logic signed [23:0] w_momv;

    logic signed [23:0] in_a;
    logic signed [22:0] q_fl;
    logic signed [31:0] q32;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] wpos;
    logic signed [24:0] resid;
    logic signed [23:0] mval;
    logic signed [35:0] tsum, qsum;

    phmdc_mixer u_mix (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mreq), .o_rsp(mrsp));

    assign in_a = s_axis_tdata[23:0];
    assign q_fl = in_a[23:1];
    assign q32  = 32'(q_fl) + 32'(in_a[0] & q_fl[0]);
    assign idx  = r_h[IDX_W-1:0];
    assign wpos = (r_cnt >= CNT_W'(PATCH_ELEMS)) ? POS_W'(PATCH_ELEMS - 1) : r_cnt[POS_W-1:0];
    assign resid = {r_b_rd[23], r_b_rd} - {r_a_rd[23], r_a_rd};
    assign mval = r_mom_ok ? r_mom_rd : 24'sd0;
    assign tsum = 36'sd179 * mval + 36'sd77 * resid + 36'sd128;
    assign qsum = {{12{r_a_rd[23]}}, r_a_rd} + (r_acc ? {{12{mval[23]}}, mval} : 36'sd0);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_oval;
    assign m_axis_tlast = r_olast;
    assign m_axis_tuser = r_oacc;

    always_comb begin
        n_state = r_state;
        n_hash = r_hash;
        n_cnt = r_cnt;
        n_i = r_i;
        n_mode = r_mode;
        n_close = r_close;
        n_h = r_h;
        n_acc = r_acc;
        n_hit = r_hit;
        n_clr = r_clr;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_oval = r_oval;
        n_olast = r_olast;
        n_oacc = r_oacc;
        mreq.start = 1'b0;
        mreq.operand = 64'd0;
        w_tag = 1'b0;
        w_hitv = 8'd0;
        w_fillv = '0;
        w_mom = 1'b0;
        w_momv = 24'sd0;
        case (r_state)
            ST_CLEAR: begin
                w_tag = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == IDX_W'(TABLE_ENTRIES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    mreq.start = 1'b1;
                    mreq.operand = {32'd0, q32} + ELEM_SALT;
                    n_mode = s_axis_tuser;
                    n_cnt = CNT_W'(wpos) + 1'b1;
                    n_close = s_axis_tlast || (CNT_W'(wpos) + 1'b1 == CNT_W'(PATCH_ELEMS));
                    n_state = ST_MIX;
                end
            end
            ST_MIX: begin
                if (mrsp.done) begin
                    n_hash = r_hash ^ mrsp.result;
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                n_hash = {r_hash[52:0], r_hash[63:53]};
                if (r_close) begin
                    mreq.start = 1'b1;
                    mreq.operand = {r_hash[52:0], r_hash[63:53]};
                    n_state = ST_FMIX;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FMIX: begin
                if (mrsp.done) begin
                    n_h = mrsp.result;
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: n_state = ST_LOOK2;
            ST_LOOK2: begin
                n_hit = (r_tag_rd == r_h) && (r_hit_rd != 8'd0 || r_h == 64'd0);
                n_acc = !r_mode && (r_hit_rd >= r_thr) && (r_tag_rd == r_h);
                if (r_mode) begin
                    w_tag = 1'b1;
                    if (n_hit) w_hitv = (r_hit_rd == 8'd255) ? 8'd255 : r_hit_rd + 8'd1;
                    else w_hitv = 8'd1;
                    w_fillv = (r_fill_rd > r_cnt) ? r_fill_rd : r_cnt;
                end
                n_i = '0;
                n_state = ST_WALK_RD;
            end
            ST_WALK_RD: n_state = ST_WALK_WAIT;
            ST_WALK_WAIT: n_state = ST_WALK_DO;
            ST_WALK_DO: begin
                if (r_mode) begin
                    w_mom = 1'b1;
                    w_momv = r_hit ? sat24(tsum >>> 8) : sat24({{11{resid[24]}}, resid});
                    if (CNT_W'(r_i) + 1'b1 == r_cnt) begin
                        n_state = ST_IDLE;
                        n_hash = HASH_SEED;
                        n_cnt = '0;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = ST_WALK_RD;
                    end
                end else if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_oval = sat24(qsum);
                    n_oacc = r_acc;
                    n_olast = (CNT_W'(r_i) + 1'b1 == r_cnt);
                    if (n_olast) begin
                        n_state = ST_IDLE;
                        n_hash = HASH_SEED;
                        n_cnt = '0;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = ST_WALK_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            buf_a[wpos] <= in_a;
            buf_b[wpos] <= s_axis_tdata[47:24];
        end
        r_a_rd <= buf_a[r_i];
        r_b_rd <= buf_b[r_i];
        if (w_tag) begin
            tag_mem[r_state == ST_CLEAR ? r_clr : idx] <= (r_state == ST_CLEAR) ? 64'd0 : r_h;
            hit_mem[r_state == ST_CLEAR ? r_clr : idx] <= w_hitv;
            fill_mem[r_state == ST_CLEAR ? r_clr : idx] <= w_fillv;
        end
        r_tag_rd <= tag_mem[idx];
        r_hit_rd <= hit_mem[idx];
        r_fill_rd <= fill_mem[idx];
        if (r_state == ST_LOOK2) r_fill <= r_fill_rd;
        r_mom_ok <= (CNT_W'(r_i) < r_fill);
        if (w_mom) mom_mem[{idx, r_i}] <= w_momv;
        r_mom_rd <= mom_mem[{idx, r_i}];
    end

    always_ff @(posedge i_clk) begin
        r_h <= n_h;
        r_oval <= n_oval;
        r_olast <= n_olast;
        r_oacc <= n_oacc;
        r_i <= n_i;
        r_mode <= n_mode;
        r_close <= n_close;
        r_hit <= n_hit;
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_thr <= 8'd3;
            r_hash <= HASH_SEED;
            r_cnt <= '0;
            r_clr <= '0;
            r_ovalid <= 1'b0;
            r_acc <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hash <= n_hash;
            r_cnt <= n_cnt;
            r_clr <= n_clr;
            r_ovalid <= n_ovalid;
            r_acc <= n_acc;
            if (i_cfg_valid) r_thr <= i_cfg_data;
        end
    end
endmodule
`default_nettype wire
